[rtl/cmu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cmu_pkg;

  typedef enum logic [1:0] {
    CMD_MAG   = 2'd0,
    CMD_CONJ  = 2'd1,
    CMD_SQRT  = 2'd2,
    CMD_RECIP = 2'd3
  } cmd_t;

  // Operand fields carried alongside the arithmetic
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] a;
    logic [15:0] b;
  } side_t;

  // Result for every command but square root, settled before the last root
  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        err;
  } res_t;

  // Divider: 16-bit magnitude numerator shifted up by 24, 32-bit divisor
  localparam int NUM_W  = 16;
  localparam int DEN_W  = 32;
  localparam int QUO_W  = 25;

  // Pipeline stage map
  localparam int SQ1_STEPS = 32;
  localparam int SQ2_STEPS = 20;
  localparam int ST_SUM    = 2;
  localparam int ST_R      = ST_SUM + SQ1_STEPS;
  localparam int ST_Q      = ST_SUM + QUO_W;
  localparam int Q_DLY     = ST_R - ST_Q;
  localparam int ST_PM     = ST_R + 1;
  localparam int LAST      = ST_PM + SQ2_STEPS;

endpackage
`default_nettype wire

[rtl/complex_math_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------
// input    | in_valid / in_ready    | command, in_real, in_imag
// output   | out_valid / out_ready  | out_real, out_imag, div_error
//
// One beat enters per cycle unless a stalled output beat holds the pipeline.
// The path to the output runs through a 32-stage radius root, one register
// for the radicands and a 20-stage second root, one bit per stage.
// Reset empties the pipeline; payload registers keep no reset.
// A stalled output beat holds the whole pipeline; nothing is lost or repeated.
module complex_math_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] in_real,
  input  wire logic [15:0] in_imag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_real,
  output logic [31:0]      out_imag,
  output logic             div_error
);

  localparam int LAST  = cmu_pkg::LAST;
  localparam int ST_R  = cmu_pkg::ST_R;
  localparam int Q_DLY = cmu_pkg::Q_DLY;
  localparam int SQ2   = cmu_pkg::SQ2_STEPS;

  logic en;
  logic [LAST:0] vld;
  cmu_pkg::side_t sd [0:LAST];

  // Advance unless a finished beat waits at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[LAST-1:0], in_valid};
      out_valid <= vld[LAST];
    end
  end

  // Carry command and operand down the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{cmd: cmu_pkg::cmd_t'(command), a: in_real, b: in_imag};
      for (int k = 1; k <= LAST; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // Squares, then their sum
  logic signed [31:0] pa, pb;
  logic [31:0] sq_a, sq_b, s_q;

  assign pa = $signed(sd[0].a) * $signed(sd[0].a);
  assign pb = $signed(sd[0].b) * $signed(sd[0].b);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a <= pa;
      sq_b <= pb;
      s_q  <= sq_a + sq_b;
    end
  end

  // Radius in Q.16: floor(sqrt(S << 32))
  logic [31:0] r_root;

  cmu_sqrt #(.RW(64)) u_sqrt_r (
    .clk  (clk),
    .en   (en),
    .rad  ({s_q, 32'd0}),
    .root (r_root)
  );

  // Reciprocal magnitudes
  logic [15:0] abs_a, abs_b;
  logic [cmu_pkg::QUO_W-1:0] qa, qb;
  logic [cmu_pkg::QUO_W-1:0] qa_d [0:Q_DLY-1];
  logic [cmu_pkg::QUO_W-1:0] qb_d [0:Q_DLY-1];

  assign abs_a = sd[cmu_pkg::ST_SUM].a[15] ? 16'(-sd[cmu_pkg::ST_SUM].a)
                                           : sd[cmu_pkg::ST_SUM].a;
  assign abs_b = sd[cmu_pkg::ST_SUM].b[15] ? 16'(-sd[cmu_pkg::ST_SUM].b)
                                           : sd[cmu_pkg::ST_SUM].b;

  cmu_div u_div_a (.clk(clk), .en(en), .num(abs_a), .den(s_q), .quo(qa));
  cmu_div u_div_b (.clk(clk), .en(en), .num(abs_b), .den(s_q), .quo(qb));

  // Delay quotients to line up with the radius
  always_ff @(posedge clk) begin
    if (en) begin
      qa_d[0] <= qa;
      qb_d[0] <= qb;
      for (int k = 1; k < Q_DLY; k++) begin
        qa_d[k] <= qa_d[k-1];
        qb_d[k] <= qb_d[k-1];
      end
    end
  end

  // Half-angle radicands and results of the other commands
  cmu_pkg::side_t      sr;
  logic signed [33:0]  a16, p_sum, m_sum;
  logic [31:0]         qa_x, qb_x;
  logic [31:0]         conj_re, conj_im;
  cmu_pkg::res_t       res_next;
  logic [32:0]         pr, mr;
  cmu_pkg::res_t       rs [0:SQ2];

  assign sr      = sd[ST_R];
  assign a16     = $signed({{2{sr.a[15]}}, sr.a, 16'd0});
  assign p_sum   = $signed({2'b00, r_root}) + a16;
  assign m_sum   = $signed({2'b00, r_root}) - a16;
  assign qa_x    = 32'(qa_d[Q_DLY-1]);
  assign qb_x    = 32'(qb_d[Q_DLY-1]);
  assign conj_re = {{8{sr.a[15]}}, sr.a, 8'd0};
  assign conj_im = 32'(-{{8{sr.b[15]}}, sr.b, 8'd0});

  always_comb begin
    res_next = '{re: 32'd0, im: 32'd0, err: 1'b0};
    case (sr.cmd)
      cmu_pkg::CMD_MAG: begin
        res_next.re = {8'd0, r_root[31:8]};
      end
      cmu_pkg::CMD_CONJ: begin
        res_next.re = conj_re;
        res_next.im = conj_im;
      end
      cmu_pkg::CMD_RECIP: begin
        if (sr.a == 16'd0 && sr.b == 16'd0) begin
          res_next.err = 1'b1;
        end else begin
          res_next.re = sr.a[15] ? 32'(-qa_x) : qa_x;
          res_next.im = sr.b[15] ? qb_x : 32'(-qb_x);
        end
      end
      default: begin
        res_next.re = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr    <= p_sum[32:0];
      mr    <= m_sum[32:0];
      rs[0] <= res_next;
      for (int k = 1; k <= SQ2; k++) begin
        rs[k] <= rs[k-1];
      end
    end
  end

  // Roots of (R +/- A) * 2^7
  logic [19:0] rp, rm;

  cmu_sqrt #(.RW(40)) u_sqrt_p (.clk(clk), .en(en), .rad({pr, 7'd0}), .root(rp));
  cmu_sqrt #(.RW(40)) u_sqrt_m (.clk(clk), .en(en), .rad({mr, 7'd0}), .root(rm));

  // Pick the result and hold it for the consumer
  always_ff @(posedge clk) begin
    if (en) begin
      if (sd[LAST].cmd == cmu_pkg::CMD_SQRT) begin
        out_real  <= 32'(rp);
        out_imag  <= sd[LAST].b[15] ? 32'(-32'(rm)) : 32'(rm);
        div_error <= 1'b0;
      end else begin
        out_real  <= rs[SQ2].re;
        out_imag  <= rs[SQ2].im;
        div_error <= rs[SQ2].err;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cmu_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root, one result bit per stage
module cmu_sqrt #(
  parameter int RW = 64
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [RW-1:0]   rad,
  output logic [RW/2-1:0]      root
);

  localparam int N    = RW / 2;
  localparam int REMW = N + 2;

  logic [REMW-1:0] rem_q  [1:N];
  logic [N-1:0]    root_q [1:N];
  logic [RW-1:0]   rad_q  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [REMW-1:0] rem_in;
    logic [N-1:0]    root_in;
    logic [RW-1:0]   rad_in;
    logic [REMW+1:0] shifted;
    logic [REMW+1:0] trial;
    logic            fit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
      assign rad_in  = rad_q[k];
    end

    // Bring down two radicand bits, try the next root bit
    assign shifted = {rem_in, rad_in[RW-1 -: 2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign fit     = shifted >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= fit ? REMW'(shifted - trial) : REMW'(shifted);
        root_q[k+1] <= {root_in[N-2:0], fit};
        rad_q[k+1]  <= {rad_in[RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[N];

endmodule
`default_nettype wire

[rtl/cmu_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: (num << 24) / den, one quotient bit per stage
module cmu_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [cmu_pkg::NUM_W-1:0]  num,
  input  wire logic [cmu_pkg::DEN_W-1:0]  den,
  output logic [cmu_pkg::QUO_W-1:0]       quo
);

  localparam int Q  = cmu_pkg::QUO_W;
  localparam int DW = cmu_pkg::DEN_W;
  localparam int NW = cmu_pkg::NUM_W;

  logic [DW-1:0] rem_q [1:Q];
  logic [Q-1:0]  quo_q [1:Q];
  logic [Q-1:0]  nb_q  [1:Q];
  logic [DW-1:0] den_q [1:Q];

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [Q-1:0]  quo_in;
    logic [Q-1:0]  nb_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   t;
    logic          fit;

    // Upper numerator bits start out below the divisor, so begin there
    if (k == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:1]);
      assign quo_in = '0;
      assign nb_in  = {num[0], {(Q-1){1'b0}}};
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[k];
      assign quo_in = quo_q[k];
      assign nb_in  = nb_q[k];
      assign den_in = den_q[k];
    end

    assign t   = {rem_in, nb_in[Q-1]};
    assign fit = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= fit ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
        quo_q[k+1] <= {quo_in[Q-2:0], fit};
        nb_q[k+1]  <= {nb_in[Q-2:0], 1'b0};
        den_q[k+1] <= den_in;
      end
    end
  end

  assign quo = quo_q[Q];

endmodule
`default_nettype wire

[rtl/cmu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module cmu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  command,
  input wire logic [15:0] in_real,
  input wire logic [15:0] in_imag,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_real,
  input wire logic [31:0] out_imag,
  input wire logic        div_error
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_real)
      && $stable(out_imag) && $stable(div_error))
    else $error("stalled result beat changed");

  // Divide-by-zero beat carries zeros
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_error |-> out_real == 32'd0 && out_imag == 32'd0)
    else $error("error beat with nonzero result");

  // Input is taken whenever no result is waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind complex_math_unit_core cmu_checker u_cmu_checker (.*);
`default_nettype wire

[bench/complex_math_unit_core_chk.sv]
`timescale 1ns / 1ps
module complex_math_unit_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] in_real,
  input  logic [15:0] in_imag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_real,
  input  logic [31:0] out_imag,
  input  logic        div_error,
  output int          fail_count,
  output int          pending
);

  cmu_pkg::res_t result_q[$];

  // floor(sqrt(v)) by restoring bit pairs
  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Compute the expected beat for one operand
  function automatic cmu_pkg::res_t complex_result(cmu_pkg::cmd_t op,
                                                   logic signed [15:0] a_in,
                                                   logic signed [15:0] b_in);
    longint a, b, re, im, a16, rad;
    logic [63:0] sum_sq;
    cmu_pkg::res_t res;
    a = a_in;
    b = b_in;
    sum_sq = a * a + b * b;
    re = 0;
    im = 0;
    res.err = 1'b0;
    case (op)
      cmu_pkg::CMD_MAG: begin
        re = int_root(sum_sq << 16);
      end
      cmu_pkg::CMD_CONJ: begin
        re = a * 256;
        im = -(b * 256);
      end
      cmu_pkg::CMD_SQRT: begin
        rad = int_root(sum_sq << 32);
        a16 = a * 65536;
        re = int_root((rad + a16) << 7);
        im = int_root((rad - a16) << 7);
        if (b < 0) im = -im;
      end
      default: begin
        if (sum_sq == 0) res.err = 1'b1;
        else begin
          re = (a * 16777216) / longint'(sum_sq);
          im = (-(b * 16777216)) / longint'(sum_sq);
        end
      end
    endcase
    res.re = re[31:0];
    res.im = im[31:0];
    return res;
  endfunction

  assign pending = result_q.size();

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    cmu_pkg::res_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        result_q.push_back(complex_result(cmu_pkg::cmd_t'(command), in_real, in_imag));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected beat re=%h im=%h err=%b", $time,
                   out_real, out_imag, div_error);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (want.re !== out_real || want.im !== out_imag ||
              want.err !== div_error) begin
            $display("%0t: expected re=%h im=%h err=%b, actual re=%h im=%h err=%b",
                     $time, want.re, want.im, want.err, out_real, out_imag, div_error);
            fail_count++;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

[bench/complex_math_unit_core_tb.sv]
`timescale 1ns / 1ps
module complex_math_unit_core_tb;

  localparam int NUM_RANDOM = 1630;
  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [15:0] in_real;
  logic [15:0] in_imag;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_real;
  logic [31:0] out_imag;
  logic        div_error;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  complex_math_unit_core DUT (.*);

  complex_math_unit_core_chk checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random backpressure on the result side
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one beat, idling first at random, and hold until accepted
  task automatic send_beat(cmu_pkg::cmd_t op, logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    in_real <= a;
    in_imag <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Pick an operand value, favoring edges and small magnitudes
  function automatic logic [15:0] pick_part();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(16)) - 8);
      3: return 16'(int'($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[6];
    int k;
    edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
    rst = 1'b1;
    in_valid = 1'b0;
    command = '0;
    in_real = '0;
    in_imag = '0;
    out_ready = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 54;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: every command on edge operands
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 6; i++)
        send_beat(cmu_pkg::cmd_t'(c), edges[i], edges[(i + c) % 6]);

    // Random, in three idling phases
    for (k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 37;
      end else if (k == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_beat(cmu_pkg::cmd_t'($urandom_range(3)), pick_part(), pick_part());
    end
    in_valid <= 1'b0;

    // Drain
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
